/* design/tksd_pkg.sv */
`default_nettype none

package tksd_pkg;

   localparam int KEY_W = 21;
   localparam int ACT_W = 5;

   // sequence phases
   localparam logic [1:0] PHASE_IDLE = 2'd0;
   localparam logic [1:0] PHASE_ESC  = 2'd1;
   localparam logic [1:0] PHASE_CSI  = 2'd2;
   localparam logic [1:0] PHASE_SS3  = 2'd3;

   // modifier bits
   localparam logic [2:0] MOD_NONE  = 3'd0;
   localparam logic [2:0] MOD_CTRL  = 3'd1;
   localparam logic [2:0] MOD_META  = 3'd2;
   localparam logic [2:0] MOD_SHIFT = 3'd4;

   // characters that steer the decoder
   localparam logic [KEY_W-1:0] CH_ESC      = 21'h1b;
   localparam logic [KEY_W-1:0] CH_CTRL_TOP = 21'h20;
   localparam logic [KEY_W-1:0] CH_CTRL_OFS = 21'h60;
   localparam logic [KEY_W-1:0] CH_DEL      = 21'h7f;
   localparam logic [KEY_W-1:0] CH_LBRACKET = 21'h5b;
   localparam logic [KEY_W-1:0] CH_UPPER_O  = 21'h4f;
   localparam logic [KEY_W-1:0] CH_DIGIT_0  = 21'h30;
   localparam logic [KEY_W-1:0] CH_DIGIT_9  = 21'h39;
   localparam logic [KEY_W-1:0] CH_LOWER_A  = 21'h61;
   localparam logic [KEY_W-1:0] CH_LOWER_D  = 21'h64;
   localparam logic [KEY_W-1:0] CH_UPPER_A  = 21'h41;
   localparam logic [KEY_W-1:0] CH_UPPER_D  = 21'h44;
   localparam logic [KEY_W-1:0] CH_UPPER_Z  = 21'h5a;
   localparam logic [KEY_W-1:0] CH_AT       = 21'h40;
   localparam logic [KEY_W-1:0] CH_CARET    = 21'h5e;
   localparam logic [KEY_W-1:0] CH_DOLLAR   = 21'h24;
   localparam logic [KEY_W-1:0] CH_TILDE    = 21'h7e;
   localparam logic [KEY_W-1:0] CH_LOWER_I  = 21'h69;

   // private key codes
   localparam logic [KEY_W-1:0] K_NOOP  = 21'hd800;
   localparam logic [KEY_W-1:0] K_UP    = 21'hd801;
   localparam logic [KEY_W-1:0] K_DOWN  = 21'hd802;
   localparam logic [KEY_W-1:0] K_LEFT  = 21'hd803;
   localparam logic [KEY_W-1:0] K_RIGHT = 21'hd804;
   localparam logic [KEY_W-1:0] K_PRIOR = 21'hd805;
   localparam logic [KEY_W-1:0] K_NEXT  = 21'hd806;
   localparam logic [KEY_W-1:0] K_HOME  = 21'hd807;
   localparam logic [KEY_W-1:0] K_END   = 21'hd808;
   localparam logic [KEY_W-1:0] K_FIND  = 21'hd809;
   localparam logic [KEY_W-1:0] K_SEL   = 21'hd80a;
   localparam logic [KEY_W-1:0] K_INS   = 21'hd80b;
   localparam logic [KEY_W-1:0] K_DEL   = 21'hd80c;
   localparam logic [KEY_W-1:0] K_F0    = 21'hd80d;

   // editing actions
   localparam logic [ACT_W-1:0] ACT_NOOP        = 5'd0;
   localparam logic [ACT_W-1:0] ACT_INSERT      = 5'd1;
   localparam logic [ACT_W-1:0] ACT_BACKSPACE   = 5'd2;
   localparam logic [ACT_W-1:0] ACT_FWD_CHAR    = 5'd3;
   localparam logic [ACT_W-1:0] ACT_BACK_CHAR   = 5'd4;
   localparam logic [ACT_W-1:0] ACT_LINE_START  = 5'd5;
   localparam logic [ACT_W-1:0] ACT_LINE_END    = 5'd6;
   localparam logic [ACT_W-1:0] ACT_INTERRUPT   = 5'd7;
   localparam logic [ACT_W-1:0] ACT_EOF         = 5'd8;
   localparam logic [ACT_W-1:0] ACT_KILL_BACK   = 5'd9;
   localparam logic [ACT_W-1:0] ACT_KILL_END    = 5'd10;
   localparam logic [ACT_W-1:0] ACT_REDRAW      = 5'd11;
   localparam logic [ACT_W-1:0] ACT_SEND        = 5'd12;
   localparam logic [ACT_W-1:0] ACT_KILL_START  = 5'd13;
   localparam logic [ACT_W-1:0] ACT_YANK        = 5'd14;
   localparam logic [ACT_W-1:0] ACT_KILL_WORD   = 5'd15;
   localparam logic [ACT_W-1:0] ACT_FWD_WORD    = 5'd16;
   localparam logic [ACT_W-1:0] ACT_BACK_WORD   = 5'd17;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic             shift_mod;
      logic             meta_mod;
      logic             ctrl_mod;
      logic [KEY_W-1:0] key_code;
   } key_result_type;

   // up, down, right, left for final letters a..d / A..D
   function automatic logic [KEY_W-1:0] arrow_code(input logic [1:0] idx);
      logic [KEY_W-1:0] k;
      k = K_UP;
      case (idx)
         2'd0:    k = K_UP;
         2'd1:    k = K_DOWN;
         2'd2:    k = K_RIGHT;
         default: k = K_LEFT;
      endcase
      return k;
   endfunction

   // function and navigation keys by csi parameter, noop past the table
   function automatic logic [KEY_W-1:0] fkey_code(input logic [5:0] idx);
      logic [KEY_W-1:0] k;
      k = K_NOOP;
      case (idx)
         6'd1:  k = K_FIND;
         6'd2:  k = K_INS;
         6'd3:  k = K_DEL;
         6'd4:  k = K_SEL;
         6'd5:  k = K_PRIOR;
         6'd6:  k = K_NEXT;
         6'd7:  k = K_HOME;
         6'd8:  k = K_END;
         6'd12: k = K_F0 + 21'd1;
         6'd13: k = K_F0 + 21'd2;
         6'd14: k = K_F0 + 21'd3;
         6'd15: k = K_F0 + 21'd4;
         6'd16: k = K_F0 + 21'd5;
         6'd18: k = K_F0 + 21'd6;
         6'd19: k = K_F0 + 21'd7;
         6'd20: k = K_F0 + 21'd8;
         6'd21: k = K_F0 + 21'd9;
         6'd22: k = K_F0 + 21'd10;
         6'd24: k = K_F0 + 21'd11;
         6'd25: k = K_F0 + 21'd12;
         6'd26: k = K_F0 + 21'd13;
         6'd27: k = K_F0 + 21'd14;
         6'd29: k = K_F0 + 21'd15;
         6'd30: k = K_F0 + 21'd16;
         6'd32: k = K_F0 + 21'd17;
         6'd33: k = K_F0 + 21'd18;
         6'd34: k = K_F0 + 21'd19;
         6'd35: k = K_F0 + 21'd20;
         default: k = K_NOOP;
      endcase
      return k;
   endfunction

   // key binding per modifier set
   function automatic logic [ACT_W-1:0] lookup_action(input logic [2:0] mods,
                                                      input logic [KEY_W-1:0] key);
      logic [ACT_W-1:0] act;
      act = ACT_NOOP;
      case (mods) inside
         MOD_CTRL: begin
            case (key)
               21'h61:  act = ACT_LINE_START;  // a
               21'h62:  act = ACT_BACK_CHAR;   // b
               21'h63:  act = ACT_INTERRUPT;   // c
               21'h64:  act = ACT_EOF;         // d
               21'h65:  act = ACT_LINE_END;    // e
               21'h66:  act = ACT_FWD_CHAR;    // f
               21'h68:  act = ACT_KILL_BACK;   // h
               21'h6b:  act = ACT_KILL_END;    // k
               21'h6c:  act = ACT_REDRAW;      // l
               21'h6d:  act = ACT_SEND;        // m
               21'h75:  act = ACT_KILL_START;  // u
               21'h79:  act = ACT_YANK;        // y
               21'h77:  act = ACT_KILL_WORD;   // w
               K_UP:    act = ACT_LINE_START;
               K_DOWN:  act = ACT_LINE_END;
               K_RIGHT: act = ACT_FWD_WORD;
               K_LEFT:  act = ACT_BACK_WORD;
               default: act = ACT_NOOP;
            endcase
         end
         MOD_META: begin
            case (key)
               21'h62:  act = ACT_BACK_WORD;   // b
               21'h66:  act = ACT_FWD_WORD;    // f
               default: act = ACT_NOOP;
            endcase
         end
         MOD_CTRL | MOD_META, MOD_SHIFT: act = ACT_NOOP;
         default: begin
            // no modifier, and shift mixed with ctrl or meta
            case (key)
               CH_DEL:  act = ACT_BACKSPACE;
               K_RIGHT: act = ACT_FWD_CHAR;
               K_LEFT:  act = ACT_BACK_CHAR;
               K_HOME:  act = ACT_LINE_START;
               K_END:   act = ACT_LINE_END;
               default: act = ACT_INSERT;
            endcase
         end
      endcase
      return act;
   endfunction

endpackage

`default_nettype wire

/* design/terminal_key_sequence_decoder_top.sv */
`default_nettype none
// stages: input register, single-pass decode, result register, then rsp_
// throughput: one item per cycle while rsp_tready does not hold the result register
// items that only advance a sequence (esc, csi and ss3 introducers, digits) give no result
// reset: synchronous, active high; clears both stage valids, the sequence phase,
// the csi parameter and the pending modifiers

module terminal_key_sequence_decoder_top #(
   parameter int FKEY_TABLE_ENTRIES = 36,
   parameter int PARAM_BITS         = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input item channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // [20:0] code_point, [23:21] zero
   // result item channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata    // [20:0] key_code, [21] ctrl_mod, [22] meta_mod,
                                         // [23] shift_mod, [28:24] action, [31:29] zero
);

   logic                       in_valid;
   logic [tksd_pkg::KEY_W-1:0] in_char;
   logic                       out_ready;
   logic                       advance;
   logic                       emit;
   tksd_pkg::key_result_type   result;

   // the decode step fires when the input register holds an item and the
   // result register is free or being emptied this cycle
   assign advance = in_valid && out_ready;

   tksd_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_char   (req_tdata[tksd_pkg::KEY_W-1:0]),
      .advance    (advance),
      .in_valid   (in_valid),
      .in_char    (in_char)
   );

   // sequence state plus key mapping and binding lookup
   tksd_decoder #(
      .FKEY_TABLE_ENTRIES (FKEY_TABLE_ENTRIES),
      .PARAM_BITS         (PARAM_BITS)
   ) u_dec (
      .clock   (clock),
      .reset   (reset),
      .fire    (advance),
      .in_char (in_char),
      .emit    (emit),
      .result  (result)
   );

   // only finished keys reach the result register
   tksd_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && emit),
      .result     (result),
      .out_ready  (out_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef ASSERT_OFF
   a_hold_when_blocked: assert property (@(posedge clock) disable iff (reset)
      in_valid && !out_ready |-> !req_tready)
      else $error("input taken while decode stage is blocked");
`endif

endmodule

`default_nettype wire

/* design/tksd_in_stage.sv */
`default_nettype none

module tksd_in_stage (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [tksd_pkg::KEY_W-1:0] req_char,
   input  wire logic                       advance,
   output logic                            in_valid,
   output logic [tksd_pkg::KEY_W-1:0]      in_char
);

   logic                       valid_ff, valid_in;
   logic [tksd_pkg::KEY_W-1:0] char_ff;
   logic                       take;

   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;
   assign valid_in   = take || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         char_ff <= req_char;
      end
   end

   assign in_valid = valid_ff;
   assign in_char  = char_ff;

endmodule

`default_nettype wire

/* design/tksd_decoder.sv */
`default_nettype none

module tksd_decoder #(
   parameter int FKEY_TABLE_ENTRIES = 36,
   parameter int PARAM_BITS         = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       fire,
   input  wire logic [tksd_pkg::KEY_W-1:0] in_char,
   output logic                            emit,
   output tksd_pkg::key_result_type        result
);

   localparam int PROD_W = PARAM_BITS + 4;

   logic [1:0]                 phase_ff, phase_in;
   logic [PARAM_BITS-1:0]      param_ff, param_in;
   logic [2:0]                 pending_ff, pending_in;
   logic [PROD_W-1:0]          prod;
   logic [PARAM_BITS-1:0]      param_sat;
   logic [tksd_pkg::KEY_W-1:0] c;
   logic [tksd_pkg::KEY_W-1:0] key;
   logic [tksd_pkg::KEY_W-1:0] fkey;
   logic [2:0]                 mods;
   logic                       fkey_past;

   // param * 10 + digit by shift and add, saturating
   assign prod = ({4'b0, param_ff} << 3) + ({4'b0, param_ff} << 1)
               + PROD_W'(in_char[3:0]);
   assign param_sat = (|prod[PROD_W-1:PARAM_BITS]) ? {PARAM_BITS{1'b1}}
                                                   : prod[PARAM_BITS-1:0];

   // past the table the final byte itself is the key
   assign fkey_past = 32'(param_ff) >= 32'(FKEY_TABLE_ENTRIES);
   assign fkey      = fkey_past ? in_char : tksd_pkg::fkey_code(param_ff[5:0]);

   always_comb begin
      c        = in_char;
      key      = in_char;
      mods     = pending_ff;
      phase_in = tksd_pkg::PHASE_IDLE;
      param_in = param_ff;
      emit     = 1'b1;
      unique case (phase_ff)
         tksd_pkg::PHASE_ESC: begin
            if (c == tksd_pkg::CH_LBRACKET) begin
               phase_in = tksd_pkg::PHASE_CSI;
               emit     = 1'b0;
            end else if (c == tksd_pkg::CH_UPPER_O) begin
               phase_in = tksd_pkg::PHASE_SS3;
               emit     = 1'b0;
            end else begin
               mods = mods | tksd_pkg::MOD_META;
               if (c == tksd_pkg::CH_ESC) begin
                  phase_in = tksd_pkg::PHASE_ESC;
                  emit     = 1'b0;
               end else if (c < tksd_pkg::CH_CTRL_TOP) begin
                  mods = mods | tksd_pkg::MOD_CTRL;
                  key  = c + tksd_pkg::CH_CTRL_OFS;
               end
            end
         end
         tksd_pkg::PHASE_CSI: begin
            if (c >= tksd_pkg::CH_DIGIT_0 && c <= tksd_pkg::CH_DIGIT_9) begin
               param_in = param_sat;
               phase_in = tksd_pkg::PHASE_CSI;
               emit     = 1'b0;
            end else begin
               param_in = '0;
               if (c >= tksd_pkg::CH_LOWER_A && c <= tksd_pkg::CH_LOWER_D) begin
                  mods = mods | tksd_pkg::MOD_SHIFT;
                  key  = tksd_pkg::arrow_code(2'(c - tksd_pkg::CH_LOWER_A));
               end else if (c >= tksd_pkg::CH_UPPER_A && c <= tksd_pkg::CH_UPPER_D) begin
                  key = tksd_pkg::arrow_code(2'(c - tksd_pkg::CH_UPPER_A));
               end else if (c == tksd_pkg::CH_UPPER_Z) begin
                  // shift-tab
                  mods = mods | tksd_pkg::MOD_SHIFT | tksd_pkg::MOD_CTRL;
                  key  = tksd_pkg::CH_LOWER_I;
               end else if (c == tksd_pkg::CH_AT) begin
                  mods = mods | tksd_pkg::MOD_SHIFT | tksd_pkg::MOD_CTRL;
                  key  = fkey;
               end else if (c == tksd_pkg::CH_CARET) begin
                  mods = mods | tksd_pkg::MOD_CTRL;
                  key  = fkey;
               end else if (c == tksd_pkg::CH_DOLLAR) begin
                  mods = mods | tksd_pkg::MOD_SHIFT;
                  key  = fkey;
               end else if (c == tksd_pkg::CH_TILDE) begin
                  key = fkey;
               end
            end
         end
         tksd_pkg::PHASE_SS3: begin
            if (c >= tksd_pkg::CH_LOWER_A && c <= tksd_pkg::CH_LOWER_D) begin
               mods = mods | tksd_pkg::MOD_CTRL;
               key  = tksd_pkg::arrow_code(2'(c - tksd_pkg::CH_LOWER_A));
            end else if (c >= tksd_pkg::CH_UPPER_A && c <= tksd_pkg::CH_UPPER_D) begin
               mods = mods | tksd_pkg::MOD_SHIFT | tksd_pkg::MOD_CTRL;
               key  = tksd_pkg::arrow_code(2'(c - tksd_pkg::CH_UPPER_A));
            end
         end
         tksd_pkg::PHASE_IDLE: begin
            if (c == tksd_pkg::CH_ESC) begin
               phase_in = tksd_pkg::PHASE_ESC;
               emit     = 1'b0;
            end else if (c < tksd_pkg::CH_CTRL_TOP) begin
               mods = mods | tksd_pkg::MOD_CTRL;
               key  = c + tksd_pkg::CH_CTRL_OFS;
            end
         end
         default: begin
            phase_in = tksd_pkg::PHASE_IDLE;
         end
      endcase
      pending_in = emit ? tksd_pkg::MOD_NONE : mods;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= tksd_pkg::PHASE_IDLE;
         param_ff   <= '0;
         pending_ff <= tksd_pkg::MOD_NONE;
      end else if (fire) begin
         phase_ff   <= phase_in;
         param_ff   <= param_in;
         pending_ff <= pending_in;
      end
   end

   assign result.key_code  = key;
   assign result.ctrl_mod  = mods[0];
   assign result.meta_mod  = mods[1];
   assign result.shift_mod = mods[2];
   assign result.action    = tksd_pkg::lookup_action(mods, key);

`ifndef ASSERT_OFF
   a_idle_no_mods: assert property (@(posedge clock) disable iff (reset)
      phase_ff == tksd_pkg::PHASE_IDLE |-> pending_ff == tksd_pkg::MOD_NONE)
      else $error("modifiers pending while idle");

   a_param_only_csi: assert property (@(posedge clock) disable iff (reset)
      phase_ff != tksd_pkg::PHASE_CSI |-> param_ff == '0)
      else $error("csi parameter left over outside csi");

   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      fire && emit |=> pending_ff == tksd_pkg::MOD_NONE
                       && phase_ff == tksd_pkg::PHASE_IDLE)
      else $error("finished key did not return to idle");
`endif

endmodule

`default_nettype wire

/* design/tksd_out_stage.sv */
`default_nettype none

module tksd_out_stage (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     load,
   input  wire tksd_pkg::key_result_type result,
   output logic                          out_ready,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [31:0]                   rsp_tdata
);

   logic                     valid_ff, valid_in;
   tksd_pkg::key_result_type data_ff;

   assign out_ready = !valid_ff || rsp_tready;
   assign valid_in  = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {3'b000, data_ff};

endmodule

`default_nettype wire

/* tb/testbench.sv */
module testbench;

   localparam int FKEY_ENTRIES = 36;
   localparam int PARAM_W      = 16;
   localparam longint unsigned PARAM_TOP = (64'd1 << PARAM_W) - 64'd1;

   localparam int N_DIRECTED   = 27;
   localparam int N_RANDOM     = 750;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_LIMIT  = 2000;
   localparam int TAIL_CYCLES  = 8;
   localparam int HOLD_CYCLES  = 80;
   localparam int IDLE_PCT     = 6;

   // ---------------------------------------------------------------------------
   // decoder copy and key checker
   // ---------------------------------------------------------------------------
   class key_scoreboard;
      logic [1:0]                 cur_phase;
      longint unsigned            csi_param;
      logic [2:0]                 held_mods;
      tksd_pkg::key_result_type   expected_keys[$];
      logic [tksd_pkg::KEY_W-1:0] arrow_keys [4];
      logic [tksd_pkg::KEY_W-1:0] fkey_keys [36];
      int                         n_errors  = 0;
      int                         n_checked = 0;
      int                         n_shown   = 0;

      function new();
         cur_phase  = tksd_pkg::PHASE_IDLE;
         csi_param  = 0;
         held_mods  = tksd_pkg::MOD_NONE;
         // final letters a..d and A..D: up, down, right, left
         arrow_keys = '{tksd_pkg::K_UP, tksd_pkg::K_DOWN, tksd_pkg::K_RIGHT,
                        tksd_pkg::K_LEFT};
         // csi parameter to navigation or function key, gaps are noop
         fkey_keys  = '{tksd_pkg::K_NOOP, tksd_pkg::K_FIND, tksd_pkg::K_INS,
                        tksd_pkg::K_DEL, tksd_pkg::K_SEL, tksd_pkg::K_PRIOR,
                        tksd_pkg::K_NEXT, tksd_pkg::K_HOME, tksd_pkg::K_END,
                        tksd_pkg::K_NOOP, tksd_pkg::K_NOOP, tksd_pkg::K_NOOP,
                        tksd_pkg::K_F0 + 21'd1, tksd_pkg::K_F0 + 21'd2,
                        tksd_pkg::K_F0 + 21'd3, tksd_pkg::K_F0 + 21'd4,
                        tksd_pkg::K_F0 + 21'd5, tksd_pkg::K_NOOP,
                        tksd_pkg::K_F0 + 21'd6, tksd_pkg::K_F0 + 21'd7,
                        tksd_pkg::K_F0 + 21'd8, tksd_pkg::K_F0 + 21'd9,
                        tksd_pkg::K_F0 + 21'd10, tksd_pkg::K_NOOP,
                        tksd_pkg::K_F0 + 21'd11, tksd_pkg::K_F0 + 21'd12,
                        tksd_pkg::K_F0 + 21'd13, tksd_pkg::K_F0 + 21'd14,
                        tksd_pkg::K_NOOP, tksd_pkg::K_F0 + 21'd15,
                        tksd_pkg::K_F0 + 21'd16, tksd_pkg::K_NOOP,
                        tksd_pkg::K_F0 + 21'd17, tksd_pkg::K_F0 + 21'd18,
                        tksd_pkg::K_F0 + 21'd19, tksd_pkg::K_F0 + 21'd20};
      endfunction

      function int pending();
         return expected_keys.size();
      endfunction

      // parameter past the table gives the final byte itself
      function logic [tksd_pkg::KEY_W-1:0] fkey_for(input logic [tksd_pkg::KEY_W-1:0] term);
         if (csi_param >= FKEY_ENTRIES)
            return term;
         if (csi_param >= 36)
            return tksd_pkg::K_NOOP;
         return fkey_keys[csi_param];
      endfunction

      function logic [tksd_pkg::ACT_W-1:0] bound_action(input logic [2:0] m,
                                                        input logic [tksd_pkg::KEY_W-1:0] k);
         logic [tksd_pkg::ACT_W-1:0] act;
         act = tksd_pkg::ACT_NOOP;
         if (m == tksd_pkg::MOD_CTRL) begin
            case (k)
               "a", tksd_pkg::K_UP:   act = tksd_pkg::ACT_LINE_START;
               "b":                   act = tksd_pkg::ACT_BACK_CHAR;
               "c":                   act = tksd_pkg::ACT_INTERRUPT;
               "d":                   act = tksd_pkg::ACT_EOF;
               "e", tksd_pkg::K_DOWN: act = tksd_pkg::ACT_LINE_END;
               "f":                   act = tksd_pkg::ACT_FWD_CHAR;
               "h":                   act = tksd_pkg::ACT_KILL_BACK;
               "k":                   act = tksd_pkg::ACT_KILL_END;
               "l":                   act = tksd_pkg::ACT_REDRAW;
               "m":                   act = tksd_pkg::ACT_SEND;
               "u":                   act = tksd_pkg::ACT_KILL_START;
               "y":                   act = tksd_pkg::ACT_YANK;
               "w":                   act = tksd_pkg::ACT_KILL_WORD;
               tksd_pkg::K_RIGHT:     act = tksd_pkg::ACT_FWD_WORD;
               tksd_pkg::K_LEFT:      act = tksd_pkg::ACT_BACK_WORD;
               default:               act = tksd_pkg::ACT_NOOP;
            endcase
         end else if (m == tksd_pkg::MOD_META) begin
            if (k == "b")
               act = tksd_pkg::ACT_BACK_WORD;
            else if (k == "f")
               act = tksd_pkg::ACT_FWD_WORD;
         end else if (m == (tksd_pkg::MOD_CTRL | tksd_pkg::MOD_META) ||
                      m == tksd_pkg::MOD_SHIFT) begin
            act = tksd_pkg::ACT_NOOP;
         end else begin
            // plain keys, and shift mixed with ctrl or meta falls back here
            case (k)
               tksd_pkg::CH_DEL:  act = tksd_pkg::ACT_BACKSPACE;
               tksd_pkg::K_RIGHT: act = tksd_pkg::ACT_FWD_CHAR;
               tksd_pkg::K_LEFT:  act = tksd_pkg::ACT_BACK_CHAR;
               tksd_pkg::K_HOME:  act = tksd_pkg::ACT_LINE_START;
               tksd_pkg::K_END:   act = tksd_pkg::ACT_LINE_END;
               default:           act = tksd_pkg::ACT_INSERT;
            endcase
         end
         return act;
      endfunction

      // advances the decoder by one code point, returns 1 when a key is finished
      function bit decode_key(input logic [tksd_pkg::KEY_W-1:0] cp,
                              output tksd_pkg::key_result_type key);
         logic [tksd_pkg::KEY_W-1:0] c;
         logic [2:0]                 m;
         longint unsigned            v;
         c   = cp;
         key = '0;
         case (cur_phase)
            tksd_pkg::PHASE_ESC: begin
               if (c == tksd_pkg::CH_LBRACKET) begin
                  cur_phase = tksd_pkg::PHASE_CSI;
                  return 0;
               end
               if (c == tksd_pkg::CH_UPPER_O) begin
                  cur_phase = tksd_pkg::PHASE_SS3;
                  return 0;
               end
               held_mods |= tksd_pkg::MOD_META;
               // esc esc: stay in the escape phase, meta already noted
               if (c == tksd_pkg::CH_ESC)
                  return 0;
               if (c < tksd_pkg::CH_CTRL_TOP) begin
                  held_mods |= tksd_pkg::MOD_CTRL;
                  c = c + tksd_pkg::CH_CTRL_OFS;
               end
            end
            tksd_pkg::PHASE_CSI: begin
               if (c >= tksd_pkg::CH_DIGIT_0 && c <= tksd_pkg::CH_DIGIT_9) begin
                  v = csi_param * 10 + longint'(c - tksd_pkg::CH_DIGIT_0);
                  csi_param = (v > PARAM_TOP) ? PARAM_TOP : v;
                  return 0;
               end
               if (c >= tksd_pkg::CH_LOWER_A && c <= tksd_pkg::CH_LOWER_D) begin
                  held_mods |= tksd_pkg::MOD_SHIFT;
                  c = arrow_keys[c - tksd_pkg::CH_LOWER_A];
               end else if (c >= tksd_pkg::CH_UPPER_A && c <= tksd_pkg::CH_UPPER_D) begin
                  c = arrow_keys[c - tksd_pkg::CH_UPPER_A];
               end else if (c == tksd_pkg::CH_UPPER_Z) begin
                  held_mods |= tksd_pkg::MOD_SHIFT | tksd_pkg::MOD_CTRL;
                  c = tksd_pkg::CH_LOWER_I;
               end else if (c == tksd_pkg::CH_AT) begin
                  held_mods |= tksd_pkg::MOD_SHIFT | tksd_pkg::MOD_CTRL;
                  c = fkey_for(c);
               end else if (c == tksd_pkg::CH_CARET) begin
                  held_mods |= tksd_pkg::MOD_CTRL;
                  c = fkey_for(c);
               end else if (c == tksd_pkg::CH_DOLLAR) begin
                  held_mods |= tksd_pkg::MOD_SHIFT;
                  c = fkey_for(c);
               end else if (c == tksd_pkg::CH_TILDE) begin
                  c = fkey_for(c);
               end
               csi_param = 0;
            end
            tksd_pkg::PHASE_SS3: begin
               if (c >= tksd_pkg::CH_LOWER_A && c <= tksd_pkg::CH_LOWER_D) begin
                  held_mods |= tksd_pkg::MOD_CTRL;
                  c = arrow_keys[c - tksd_pkg::CH_LOWER_A];
               end else if (c >= tksd_pkg::CH_UPPER_A && c <= tksd_pkg::CH_UPPER_D) begin
                  held_mods |= tksd_pkg::MOD_SHIFT | tksd_pkg::MOD_CTRL;
                  c = arrow_keys[c - tksd_pkg::CH_UPPER_A];
               end
            end
            default: begin
               if (c == tksd_pkg::CH_ESC) begin
                  cur_phase = tksd_pkg::PHASE_ESC;
                  return 0;
               end
               if (c < tksd_pkg::CH_CTRL_TOP) begin
                  held_mods |= tksd_pkg::MOD_CTRL;
                  c = c + tksd_pkg::CH_CTRL_OFS;
               end
            end
         endcase
         cur_phase     = tksd_pkg::PHASE_IDLE;
         m             = held_mods;
         held_mods     = tksd_pkg::MOD_NONE;
         key.key_code  = c;
         key.ctrl_mod  = m[0];
         key.meta_mod  = m[1];
         key.shift_mod = m[2];
         key.action    = bound_action(m, c);
         return 1;
      endfunction

      function void note_code_point(input logic [tksd_pkg::KEY_W-1:0] cp);
         tksd_pkg::key_result_type key;
         if (decode_key(cp, key))
            expected_keys.push_back(key);
      endfunction

      function void check_key(input logic [31:0] data);
         tksd_pkg::key_result_type got;
         tksd_pkg::key_result_type want;
         got = tksd_pkg::key_result_type'(data[$bits(tksd_pkg::key_result_type)-1:0]);
         n_checked++;
         if (expected_keys.size() == 0) begin
            n_errors++;
            if (n_shown < 10) begin
               n_shown++;
               $display("unexpected key: key %h c%b m%b s%b act %0d", got.key_code,
                        got.ctrl_mod, got.meta_mod, got.shift_mod, got.action);
            end
            return;
         end
         want = expected_keys.pop_front();
         if (got.key_code != want.key_code || got.ctrl_mod != want.ctrl_mod ||
             got.meta_mod != want.meta_mod || got.shift_mod != want.shift_mod ||
             got.action != want.action) begin
            n_errors++;
            if (n_shown < 10) begin
               n_shown++;
               $display({"key mismatch: expected key %h c%b m%b s%b act %0d,",
                         " got key %h c%b m%b s%b act %0d"},
                        want.key_code, want.ctrl_mod, want.meta_mod, want.shift_mod,
                        want.action, got.key_code, got.ctrl_mod, got.meta_mod,
                        got.shift_mod, got.action);
            end
         end
      endfunction
   endclass

   // ---------------------------------------------------------------------------
   // clock, reset and block
   // ---------------------------------------------------------------------------
   logic              clock;
   logic              reset       = 1'b1;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic [23:0]       req_tdata   = '0;   // [20:0] code_point, [23:21] zero
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   logic [31:0]       rsp_tdata;          // [20:0] key_code, [21] ctrl_mod, [22] meta_mod,
                                          // [23] shift_mod, [28:24] action, [31:29] zero
   int unsigned       cycle_count = 0;

   key_scoreboard              book;
   logic [tksd_pkg::KEY_W-1:0] key_stream[$];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   terminal_key_sequence_decoder_top #(
      .FKEY_TABLE_ENTRIES (FKEY_ENTRIES),
      .PARAM_BITS         (PARAM_W)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------
   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++)
         key_stream.push_back({13'd0, s[i]});
   endtask

   // offers one code point and returns at the edge that takes it
   task automatic send_code(input logic [tksd_pkg::KEY_W-1:0] cp, input bit may_idle);
      while (may_idle && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, cp};
      do begin
         @(posedge clock);
      end while (!req_tready);
      book.note_code_point(cp);
   endtask

   // ---------------------------------------------------------------------------
   // result side: random stalls, one long hold-off so the block backs up
   // ---------------------------------------------------------------------------
   initial begin
      int hold_left;
      bit held_once;
      hold_left = 0;
      held_once = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            book.check_key(rsp_tdata);
         if (!held_once && book.n_checked >= 60) begin
            held_once = 1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (book.n_checked >= 120 && book.n_checked < 180) begin
            // stretch with no stalls at all
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------
   initial begin
      string finals;
      int    sel;
      int    waited;
      int    n_items;
      finals = "ABCDabcdZ@^$~";
      book   = new();

      // directed: plain, delete, control letter, top code point
      push_text("a");
      key_stream.push_back(tksd_pkg::CH_DEL);
      key_stream.push_back(21'h03);
      key_stream.push_back(21'h1fffff);
      // meta with control letter, which has no binding table
      key_stream.push_back(tksd_pkg::CH_ESC);
      key_stream.push_back(21'h02);
      // esc esc carries meta into the csi arrow
      key_stream.push_back(tksd_pkg::CH_ESC);
      key_stream.push_back(tksd_pkg::CH_ESC);
      push_text("[A");
      // parameter saturates, then past the table
      key_stream.push_back(tksd_pkg::CH_ESC);
      push_text("[999999$");
      // function key from the table
      key_stream.push_back(tksd_pkg::CH_ESC);
      push_text("[24~");
      // ss3 upper-case arrow, shift with ctrl falls back to the normal table
      key_stream.push_back(tksd_pkg::CH_ESC);
      push_text("OB");

      // random part, mostly well-formed sequences with random content
      while (key_stream.size() < N_DIRECTED + N_RANDOM) begin
         sel = $urandom_range(99);
         if (sel < 15) begin
            key_stream.push_back(tksd_pkg::KEY_W'($urandom_range(32, 126)));
         end else if (sel < 22) begin
            key_stream.push_back(tksd_pkg::KEY_W'($urandom_range(31)));
         end else if (sel < 30) begin
            key_stream.push_back(tksd_pkg::KEY_W'($urandom_range(21'h1fffff)));
         end else if (sel < 42) begin
            // meta prefix on an arbitrary character
            key_stream.push_back(tksd_pkg::CH_ESC);
            sel = $urandom_range(99);
            if (sel < 25)
               push_text(sel[0] ? "b" : "f");
            else if (sel < 55)
               key_stream.push_back(tksd_pkg::KEY_W'($urandom_range(32, 126)));
            else if (sel < 85)
               key_stream.push_back(tksd_pkg::KEY_W'($urandom_range(31)));
            else
               key_stream.push_back(tksd_pkg::KEY_W'($urandom_range(21'h1fffff)));
         end else if (sel < 47) begin
            // lone esc, whatever comes next gets meta
            key_stream.push_back(tksd_pkg::CH_ESC);
         end else if (sel < 85) begin
            key_stream.push_back(tksd_pkg::CH_ESC);
            push_text("[");
            sel = $urandom_range(99);
            if (sel < 55) begin
               if (sel >= 5)
                  push_text($sformatf("%0d", $urandom_range(40)));
            end else if (sel < 70) begin
               push_text($sformatf("%0d", $urandom_range(99999)));
            end else if (sel < 78) begin
               push_text($sformatf("%0d%0d", $urandom_range(999999), $urandom_range(9999)));
            end else if (sel < 85) begin
               push_text($sformatf("00%0d", $urandom_range(35)));
            end
            sel = $urandom_range(99);
            if (sel < 85)
               key_stream.push_back({13'd0, finals[$urandom_range(finals.len() - 1)]});
            else if (sel < 93)
               key_stream.push_back(tksd_pkg::KEY_W'($urandom_range(32, 126)));
            else
               key_stream.push_back(tksd_pkg::KEY_W'($urandom_range(21'h1fffff)));
         end else begin
            key_stream.push_back(tksd_pkg::CH_ESC);
            push_text("O");
            sel = $urandom_range(99);
            if (sel < 40)
               key_stream.push_back(tksd_pkg::KEY_W'($urandom_range(tksd_pkg::CH_LOWER_A,
                                                                     tksd_pkg::CH_LOWER_D)));
            else if (sel < 80)
               key_stream.push_back(tksd_pkg::KEY_W'($urandom_range(tksd_pkg::CH_UPPER_A,
                                                                     tksd_pkg::CH_UPPER_D)));
            else if (sel < 92)
               key_stream.push_back(tksd_pkg::KEY_W'($urandom_range(32, 126)));
            else
               key_stream.push_back(tksd_pkg::KEY_W'($urandom_range(21'h1fffff)));
         end
      end
      n_items = key_stream.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < n_items; i++) begin
         // once: let the block drain completely before going on
         if (i == 600) begin
            req_tvalid <= 1'b0;
            do begin
               @(posedge clock);
            end while (book.pending() != 0);
         end
         send_code(key_stream[i], !(i >= 250 && i < 450));
      end
      req_tvalid <= 1'b0;

      waited = 0;
      while (book.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      if (book.pending() != 0) begin
         $display("%0d keys never arrived", book.pending());
         book.n_errors += book.pending();
      end
      if (book.n_errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
